// ===== src/bist_pkg.sv =====
package bist_pkg;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam int COUNT_OUT_W = 5;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic                   success;
      logic                   full_refused;
      logic [COUNT_OUT_W-1:0] member_count;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/bist_req_if.sv =====
interface bist_req_if;
   import bist_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/bist_rsp_if.sv =====
interface bist_rsp_if;
   import bist_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/bist_ctrl.sv =====
module bist_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bist_pkg::dp_status_type status,
   output bist_pkg::dp_cmd_type    cmd
);
   import bist_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_UPD  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.compare = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            // hold until the result register can take the new beat
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/bist_dp.sv =====
module bist_dp #(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bist_pkg::dp_cmd_type      cmd,
   output bist_pkg::dp_status_type   status,
   input  bist_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bist_pkg::rsp_payload_type rsp_payload
);
   import bist_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int XW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

   logic [1:0]          op_ff;
   logic [31:0]         value_ff;
   logic [CAPACITY-1:0] match_ff, match_in;
   logic [31:0]         slot_ff [CAPACITY];
   logic [31:0]         slot_in [CAPACITY];
   logic [CAPACITY-1:0] slot_we;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_ff, rsp_in;

   logic [CAPACITY-1:0] pre [IW+1];
   logic                found, full, ins_ok, rem_ok;
   logic [XW-1:0]       count_x;

   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         match_in[j] = (slot_ff[j] == value_ff) && (CW'(j) < count_ff);
      end
   end

   // first-match-and-above mask, log-depth prefix OR
   always_comb begin
      pre[0] = match_ff;
      for (int k = 0; k < IW; k++) begin
         for (int j = 0; j < CAPACITY; j++) begin
            if (j >= (1 << k)) begin
               pre[k+1][j] = pre[k][j] | pre[k][j - (1 << k)];
            end else begin
               pre[k+1][j] = pre[k][j];
            end
         end
      end
   end

   always_comb begin
      found  = |match_ff;
      full   = (count_ff == CW'(CAPACITY));
      ins_ok = (op_ff == OP_INSERT) && !found && !full;
      rem_ok = (op_ff == OP_REMOVE) && found;

      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + CW'(1);
      end else if (rem_ok) begin
         count_in = count_ff - CW'(1);
      end

      for (int j = 0; j < CAPACITY; j++) begin
         slot_we[j] = 1'b0;
         slot_in[j] = value_ff;
         if (ins_ok && (count_ff == CW'(j))) begin
            slot_we[j] = 1'b1;
         end else if (j < CAPACITY - 1) begin
            if (rem_ok && pre[IW][j] && (CW'(j + 1) < count_ff)) begin
               slot_we[j] = 1'b1;
               slot_in[j] = slot_ff[j + 1];
            end
         end
      end

      count_x = XW'(count_in);
      rsp_in.success      = 1'b0;
      rsp_in.full_refused = 1'b0;
      rsp_in.member_count = count_x[COUNT_OUT_W-1:0];
      case (op_ff)
         OP_LOOKUP: rsp_in.success = found;
         OP_INSERT: begin
            rsp_in.success      = ins_ok;
            rsp_in.full_refused = !found && full;
         end
         OP_REMOVE: rsp_in.success = rem_ok;
         default:   rsp_in.success = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_payload.opcode;
         value_ff <= req_payload.value;
      end
      if (cmd.compare) begin
         match_ff <= match_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         for (int j = 0; j < CAPACITY; j++) begin
            if (slot_we[j]) begin
               slot_ff[j] <= slot_in[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

endmodule

// ===== src/bounded_integer_set_table_core.sv =====
// Bounded set of up to CAPACITY distinct signed 32-bit values, held in slots
// 0 to count-1 with an occupancy count. A request beat carries an opcode
// (lookup, insert, remove) and a value; each one yields exactly one response
// beat with success, full_refused and the member count after the operation
// (low 5 bits). An accepted beat goes through these steps in order: the request is
// captured, the value is compared against every slot at once, and the append or
// the shift-down is applied while the response register is loaded. The next
// request is taken in the cycle after that update, while the previous
// response may still wait; the update cycle stalls only while an untaken
// response holds the output register. After reset the set is empty and is
// usable at once.
module bounded_integer_set_table_core #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   bist_req_if.sink   req_chan,
   bist_rsp_if.source rsp_chan
);
   import bist_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   bist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bist_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

// ===== tb/tb_bounded_integer_set_table_core.sv =====
module tb_bounded_integer_set_table_core;
   import bist_pkg::*;

   localparam int SET_CAPACITY = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_OPS = 1300;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;

   bist_req_if req_chan();
   bist_rsp_if rsp_chan();

   bounded_integer_set_table_core #(
      .CAPACITY(SET_CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   req_payload_type queued_ops[$];
   rsp_payload_type awaited_outcomes[$];
   logic [31:0]     mirror_slots[SET_CAPACITY];
   int              mirror_count;
   logic [31:0]     value_pool[$];

   int  mismatches;
   int  cycles;
   int  req_hold;
   int  rsp_hold;
   bit  req_burst;
   bit  rsp_burst;
   bit  req_taken;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // set semantics: append on insert, shift down on remove
   function automatic rsp_payload_type apply_set_op(req_payload_type beat);
      int              hit;
      rsp_payload_type res;
      hit = -1;
      res = '0;
      for (int i = 0; i < mirror_count; i++) begin
         if (hit < 0 && mirror_slots[i] == beat.value) begin
            hit = i;
         end
      end
      case (beat.opcode)
         OP_LOOKUP: begin
            res.success = (hit >= 0);
         end
         OP_INSERT: begin
            if (hit < 0) begin
               if (mirror_count >= SET_CAPACITY) begin
                  res.full_refused = 1'b1;
               end else begin
                  mirror_slots[mirror_count] = beat.value;
                  mirror_count++;
                  res.success = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               for (int j = hit; j + 1 < mirror_count; j++) begin
                  mirror_slots[j] = mirror_slots[j + 1];
               end
               mirror_count--;
               res.success = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.member_count = mirror_count[COUNT_OUT_W-1:0];
      return res;
   endfunction

   function automatic int pick_gap(bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) begin
         return 0;
      end
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic void push_op(logic [1:0] op, logic [31:0] v);
      req_payload_type beat;
      beat.opcode = op;
      beat.value = v;
      queued_ops.push_back(beat);
   endfunction

   function automatic logic [31:0] pick_value(int pool_pct);
      if ($urandom_range(0, 99) < pool_pct) begin
         return value_pool[$urandom_range(0, value_pool.size() - 1)];
      end
      return $urandom;
   endfunction

   task automatic wait_quiet();
      while (queued_ops.size() != 0 || req_chan.valid || awaited_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.payload <= '0;
         req_hold = 0;
      end else if (!req_chan.valid || req_taken) begin
         if ($urandom_range(0, 49) == 0) begin
            req_burst = ~req_burst;
         end
         if (req_hold > 0) begin
            req_chan.valid <= 1'b0;
            req_hold--;
         end else if (queued_ops.size() != 0) begin
            req_chan.valid <= 1'b1;
            req_chan.payload <= queued_ops.pop_front();
            req_hold = pick_gap(req_burst);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if ($urandom_range(0, 49) == 0) begin
            rsp_burst = ~rsp_burst;
         end
         if (rsp_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_hold = pick_gap(rsp_burst);
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            awaited_outcomes.push_back(apply_set_op(req_chan.payload));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected rsp beat: success=%b full_refused=%b count=%0d",
                     rsp_chan.payload.success, rsp_chan.payload.full_refused,
                     rsp_chan.payload.member_count);
               end
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_chan.payload.success !== want.success ||
                   rsp_chan.payload.full_refused !== want.full_refused ||
                   rsp_chan.payload.member_count !== want.member_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("rsp mismatch: exp success=%b full_refused=%b count=%0d",
                        want.success, want.full_refused, want.member_count);
                     $display("              got success=%b full_refused=%b count=%0d",
                        rsp_chan.payload.success, rsp_chan.payload.full_refused,
                        rsp_chan.payload.member_count);
                  end
               end
            end
         end
      end
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int r;
      bit grow;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      mismatches = 0;
      cycles = 0;
      req_hold = 0;
      rsp_hold = 0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      mirror_count = 0;
      for (int i = 0; i < SET_CAPACITY; i++) begin
         mirror_slots[i] = '0;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty set, extremes, duplicates, full set, shifts
      push_op(OP_LOOKUP, 32'h0000_0000);
      push_op(OP_INSERT, 32'h8000_0000);
      push_op(OP_INSERT, 32'h7FFF_FFFF);
      push_op(OP_INSERT, 32'h0000_0000);
      push_op(OP_INSERT, 32'hFFFF_FFFF);
      push_op(OP_INSERT, 32'hFFFF_FFFF);
      push_op(OP_LOOKUP, 32'h7FFF_FFFF);
      push_op(OP_LOOKUP, 32'h1234_5678);
      push_op(OP_REMOVE, 32'h1234_5678);
      push_op(OP_UNUSED, 32'h0000_0000);
      for (int k = 0; k < SET_CAPACITY - 4; k++) begin
         push_op(OP_INSERT, 32'hA5A5_0000 | k);
      end
      push_op(OP_INSERT, 32'h1357_9BDF);
      push_op(OP_INSERT, 32'h0000_0000);
      push_op(OP_REMOVE, 32'h8000_0000);
      push_op(OP_REMOVE, 32'hA5A5_0000 | (SET_CAPACITY - 5));
      push_op(OP_REMOVE, 32'h0000_0000);
      push_op(OP_INSERT, 32'h1357_9BDF);
      wait_quiet();

      value_pool.push_back(32'h0000_0000);
      value_pool.push_back(32'hFFFF_FFFF);
      value_pool.push_back(32'h8000_0000);
      value_pool.push_back(32'h7FFF_FFFF);
      value_pool.push_back(32'h0000_0001);
      for (int k = 0; k < 19; k++) begin
         value_pool.push_back($urandom);
      end

      grow = 1'b1;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 100 == 0) begin
            grow = ~grow;
            value_pool[$urandom_range(5, value_pool.size() - 1)] = $urandom;
         end
         if (n == RANDOM_OPS / 2) begin
            wait_quiet();
         end
         r = $urandom_range(0, 99);
         if (r < 3) begin
            push_op(OP_UNUSED, pick_value(50));
         end else if (grow) begin
            if (r < 63) begin
               push_op(OP_INSERT, pick_value(70));
            end else if (r < 78) begin
               push_op(OP_REMOVE, pick_value(85));
            end else begin
               push_op(OP_LOOKUP, pick_value(75));
            end
         end else begin
            if (r < 23) begin
               push_op(OP_INSERT, pick_value(70));
            end else if (r < 73) begin
               push_op(OP_REMOVE, pick_value(90));
            end else begin
               push_op(OP_LOOKUP, pick_value(75));
            end
         end
      end

      wait_quiet();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
